// ===== rtl/htp_pkg.sv =====
// Types, constants and microcode program shared by the heading turn PID block.
package htp_pkg;

  // Input beat: one control tick
  typedef struct packed {
    logic        start_move;
    logic [8:0]  target_angle;
    logic [15:0] heading;
  } in_t;

  // Output beat: one drive result
  typedef struct packed {
    logic signed [15:0] drive;
    logic               settled;
  } out_t;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] integral_gain;
    logic [15:0] derivative_gain;
    logic [15:0] integral_limit;
    logic [10:0] integral_boost_band;
    logic [14:0] settle_band;
  } cfg_t;

  // Register indexes on the config port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRAL_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DERIVATIVE_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRAL_LIMIT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BOOST_BAND      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_BAND     = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_INTEGRAL_GAIN   = 16'd3932;
  localparam logic [15:0] RST_DERIVATIVE_GAIN = 16'd20316;
  localparam logic [15:0] RST_INTEGRAL_LIMIT  = 16'd1536;
  localparam logic [10:0] RST_BOOST_BAND      = 11'd8;
  localparam logic [14:0] RST_SETTLE_BAND     = 15'd128;

  // Arithmetic constants
  localparam logic signed [18:0] FULL_TURN   = 19'sd46080;   // 360 deg in 1/128 deg
  localparam logic signed [18:0] ERR_MAX     = 19'sd32767;
  localparam logic signed [31:0] GAIN_OFS    = 32'sd36992;   // 289 deg * 128
  localparam logic signed [35:0] GAIN_BIAS   = 36'sd533801970; // 32580*16384 + half of 22500
  localparam logic signed [31:0] GAIN_RECIP  = 32'sd1563749871; // ceil(2^45 / 22500)
  localparam int unsigned        RECIP_SHIFT = 45;
  localparam logic signed [35:0] ROUND_HALF  = 36'sd16384;
  localparam logic signed [20:0] DRIVE_MAX   = 21'sd32767;

  // Sequencer step codes
  typedef logic [3:0] step_t;
  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_LR   = 4'd1;
  localparam step_t ST_ERR  = 4'd2;
  localparam step_t ST_BR   = 4'd3;
  localparam step_t ST_GSQ  = 4'd4;
  localparam step_t ST_GN   = 4'd5;
  localparam step_t ST_GDIV = 4'd6;
  localparam step_t ST_GSET = 4'd7;
  localparam step_t ST_INTG = 4'd8;
  localparam step_t ST_PI   = 4'd9;
  localparam step_t ST_PD   = 4'd10;
  localparam step_t ST_SUM  = 4'd11;
  localparam step_t ST_DRV  = 4'd12;
  localparam step_t ST_OUT  = 4'd13;

  typedef enum logic [1:0] {
    C_NEXT,      // fall through
    C_WAIT_IN,   // hold until an input beat is taken
    C_SKIP_GAIN, // jump to target unless the move starts
    C_WAIT_OUT   // hold until the output register is free, then jump
  } cond_e;

  typedef enum logic [2:0] {
    MA_ABS_ERR,
    MA_ACC,
    MA_ERR,
    MA_INTG,
    MA_DERIV
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_ABS_OFS,
    MB_RECIP,
    MB_KP,
    MB_KI,
    MB_KD
  } mul_b_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_N,
    ACC_LOAD,
    ACC_ADD
  } acc_e;

  // One microcode control word
  typedef struct packed {
    cond_e  cond;
    step_t  target;
    mul_a_e ma;
    mul_b_e mb;
    logic   mul_en;
    acc_e   acc;
    logic   ld_in;
    logic   ld_lr;
    logic   ld_err;
    logic   ld_kp;
    logic   ld_intg;
    logic   ld_drive;
    logic   ld_out;
  } ctrl_t;

  // Handshake status seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic start;
    logic out_free;
  } stat_t;

  // Microcode ROM
  function automatic ctrl_t mcode(step_t s);
    ctrl_t c;
    c = '0;
    unique case (s)
      ST_IDLE: begin
        c.cond  = C_WAIT_IN;
        c.ld_in = 1'b1;
      end
      ST_LR:   c.ld_lr = 1'b1;
      ST_ERR:  c.ld_err = 1'b1;
      ST_BR: begin
        c.cond   = C_SKIP_GAIN;
        c.target = ST_INTG;
      end
      ST_GSQ: begin
        c.ma     = MA_ABS_ERR;
        c.mb     = MB_ABS_OFS;
        c.mul_en = 1'b1;
      end
      ST_GN:   c.acc = ACC_LOAD_N;
      ST_GDIV: begin
        c.ma     = MA_ACC;
        c.mb     = MB_RECIP;
        c.mul_en = 1'b1;
      end
      ST_GSET: c.ld_kp = 1'b1;
      ST_INTG: begin
        c.ld_intg = 1'b1;
        c.ma      = MA_ERR;
        c.mb      = MB_KP;
        c.mul_en  = 1'b1;
      end
      ST_PI: begin
        c.acc    = ACC_LOAD;
        c.ma     = MA_INTG;
        c.mb     = MB_KI;
        c.mul_en = 1'b1;
      end
      ST_PD: begin
        c.acc    = ACC_ADD;
        c.ma     = MA_DERIV;
        c.mb     = MB_KD;
        c.mul_en = 1'b1;
      end
      ST_SUM:  c.acc = ACC_ADD;
      ST_DRV:  c.ld_drive = 1'b1;
      ST_OUT: begin
        c.cond   = C_WAIT_OUT;
        c.target = ST_IDLE;
        c.ld_out = 1'b1;
      end
      default: begin
        c.cond   = C_WAIT_OUT;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/heading_turn_pid.sv =====
// Heading turn PID controller top level: config registers and output register.
// Each beat runs the microcode steps in order, the gain recompute only on start_move.
// A new beat is taken only once the last result is loaded into the output register,
// which holds the sequencer while full. All products share one multiplier.
// Reset: config registers take their defaults, gain, integral and last error clear,
// the sequencer returns to its idle step and the output register empties.
module heading_turn_pid
  import htp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  cfg_t  cfg_q;
  ctrl_t ctrl;
  stat_t stat;
  out_t  res;
  out_t  out_q;
  logic  out_valid_q;
  logic  start;

  assign cfg_ready_o = 1'b1;

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.integral_gain       <= RST_INTEGRAL_GAIN;
      cfg_q.derivative_gain     <= RST_DERIVATIVE_GAIN;
      cfg_q.integral_limit      <= RST_INTEGRAL_LIMIT;
      cfg_q.integral_boost_band <= RST_BOOST_BAND;
      cfg_q.settle_band         <= RST_SETTLE_BAND;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INTEGRAL_GAIN:   cfg_q.integral_gain       <= cfg_data_i;
        CFG_DERIVATIVE_GAIN: cfg_q.derivative_gain     <= cfg_data_i;
        CFG_INTEGRAL_LIMIT:  cfg_q.integral_limit      <= cfg_data_i;
        CFG_BOOST_BAND:      cfg_q.integral_boost_band <= cfg_data_i[10:0];
        CFG_SETTLE_BAND:     cfg_q.settle_band         <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign stat.in_fire  = in_valid_i && in_ready_o;
  assign stat.start    = start;
  assign stat.out_free = !out_valid_q || out_ready_i;

  htp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  htp_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .in_i    (in_data_i),
    .start_o (start),
    .res_o   (res)
  );

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/htp_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module htp_seq
  import htp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output logic  in_ready_o,
  output ctrl_t ctrl_o
);

  step_t step_q, step_d;
  ctrl_t word;
  logic  go;

  // Fetch and branch
  always_comb begin
    word = mcode(step_q);
    go   = 1'b1;
    unique case (word.cond)
      C_NEXT: begin
        step_d = step_t'(step_q + 4'd1);
      end
      C_WAIT_IN: begin
        go     = stat_i.in_fire;
        step_d = go ? step_t'(step_q + 4'd1) : step_q;
      end
      C_SKIP_GAIN: begin
        step_d = stat_i.start ? step_t'(step_q + 4'd1) : word.target;
      end
      C_WAIT_OUT: begin
        go     = stat_i.out_free;
        step_d = go ? word.target : step_q;
      end
    endcase
  end

  // Loads only happen once a wait condition is met
  always_comb begin
    ctrl_o = word;
    if (!go) begin
      ctrl_o.ld_in    = 1'b0;
      ctrl_o.ld_lr    = 1'b0;
      ctrl_o.ld_err   = 1'b0;
      ctrl_o.ld_kp    = 1'b0;
      ctrl_o.ld_intg  = 1'b0;
      ctrl_o.ld_drive = 1'b0;
      ctrl_o.ld_out   = 1'b0;
    end
  end

  assign in_ready_o = (word.cond == C_WAIT_IN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/htp_dp.sv =====
// Datapath: turn error, shared multiplier, accumulator and PID state.
module htp_dp
  import htp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  cfg_t  cfg_i,
  input  in_t   in_i,
  output logic  start_o,
  output out_t  res_o
);

  in_t                in_q;
  logic signed [18:0] l_q, r_q;
  logic signed [15:0] err_q;
  logic        [15:0] kp_q;
  logic signed [17:0] intg_q;
  logic signed [15:0] last_q;
  logic signed [61:0] prod_q;
  logic signed [35:0] acc_q;
  logic signed [15:0] drive_q;

  logic signed [18:0] a_w, h_w, l_d, r_d, abs_r, e_w;
  logic signed [15:0] err_d, abs16, absd16;
  logic        [14:0] abs_err, abs_drv;
  logic signed [16:0] deriv;
  logic        [17:0] mag_i;
  logic signed [17:0] err_ext, intg_d;
  logic               boost, sign_diff;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_w;
  logic signed [35:0] rnd;
  logic signed [20:0] q_w;
  logic signed [15:0] drive_d;

  assign start_o = in_q.start_move;

  // Both ways round the circle
  always_comb begin
    a_w = $signed({3'b000, in_q.target_angle, 7'b0000000});
    h_w = $signed({3'b000, in_q.heading});
    if (a_w > h_w) begin
      l_d = a_w - h_w;
      r_d = FULL_TURN - a_w + h_w;
    end else begin
      l_d = FULL_TURN - h_w + a_w;
      r_d = h_w - a_w;
    end
  end

  // Shorter way, saturated to 16 bits
  always_comb begin
    abs_r = r_q[18] ? -r_q : r_q;
    e_w   = (l_q > abs_r) ? -r_q : l_q;
    if (e_w > ERR_MAX) begin
      err_d = 16'sh7fff;
    end else if (e_w < -ERR_MAX) begin
      err_d = -16'sh7fff;
    end else begin
      err_d = e_w[15:0];
    end
  end

  assign abs16   = err_q[15] ? -err_q : err_q;
  assign abs_err = abs16[14:0];
  assign deriv   = {err_q[15], err_q} - {last_q[15], last_q};
  assign err_ext = {{2{err_q[15]}}, err_q};

  // Integral update: limit clear, boost band, sign change clear
  always_comb begin
    mag_i     = intg_q[17] ? 18'(-intg_q) : intg_q;
    boost     = (cfg_i.integral_gain != 16'd0) &&
                (abs_err < {4'b0000, cfg_i.integral_boost_band});
    sign_diff = ((err_q > 16'sd0) != (last_q > 16'sd0)) ||
                ((err_q < 16'sd0) != (last_q < 16'sd0));
    if (mag_i > {2'b00, cfg_i.integral_limit}) begin
      intg_d = '0;
    end else if ((cfg_i.integral_gain != 16'd0) && sign_diff) begin
      intg_d = '0;
    end else begin
      intg_d = intg_q + err_ext + (boost ? err_ext : 18'sd0);
    end
  end

  // Shared multiplier operands
  always_comb begin
    case (ctrl_i.ma)
      MA_ABS_ERR: ma = $signed({17'd0, abs_err});
      MA_ACC:     ma = acc_q[31:0];
      MA_ERR:     ma = 32'(err_q);
      MA_INTG:    ma = 32'(intg_q);
      MA_DERIV:   ma = 32'(deriv);
      default:    ma = '0;
    endcase
    case (ctrl_i.mb)
      MB_ABS_OFS: mb = $signed({17'd0, abs_err}) - GAIN_OFS;
      MB_RECIP:   mb = GAIN_RECIP;
      MB_KP:      mb = $signed({16'd0, kp_q});
      MB_KI:      mb = $signed({16'd0, cfg_i.integral_gain});
      MB_KD:      mb = $signed({16'd0, cfg_i.derivative_gain});
      default:    mb = '0;
    endcase
  end

  assign prod_w = ma * mb;

  // Round half up from Q20.15 to a whole drive value and saturate
  always_comb begin
    rnd = acc_q + ROUND_HALF;
    q_w = rnd[35:15];
    if (q_w > DRIVE_MAX) begin
      drive_d = 16'sh7fff;
    end else if (q_w < -DRIVE_MAX) begin
      drive_d = -16'sh7fff;
    end else begin
      drive_d = q_w[15:0];
    end
  end

  assign absd16        = drive_q[15] ? -drive_q : drive_q;
  assign abs_drv       = absd16[14:0];
  assign res_o.drive   = drive_q;
  assign res_o.settled = abs_drv < cfg_i.settle_band;

  // Working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_in) begin
      in_q <= in_i;
    end
    if (ctrl_i.ld_lr) begin
      l_q <= l_d;
      r_q <= r_d;
    end
    if (ctrl_i.ld_err) begin
      err_q <= err_d;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_w[61:0];
    end
    unique case (ctrl_i.acc)
      ACC_HOLD:   acc_q <= acc_q;
      ACC_LOAD_N: acc_q <= prod_q[35:0] + GAIN_BIAS;
      ACC_LOAD:   acc_q <= prod_q[35:0];
      ACC_ADD:    acc_q <= acc_q + prod_q[35:0];
    endcase
    if (ctrl_i.ld_drive) begin
      drive_q <= drive_d;
    end
  end

  // Controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      intg_q <= '0;
      last_q <= '0;
    end else begin
      if (ctrl_i.ld_kp) begin
        kp_q <= prod_q[RECIP_SHIFT+15:RECIP_SHIFT];
      end
      if (ctrl_i.ld_intg) begin
        intg_q <= intg_d;
      end
      if (ctrl_i.ld_out && !res_o.settled) begin
        last_q <= err_q;
      end
    end
  end

endmodule

// ===== test/htp_drive_monitor.sv =====
// Drive monitor for the heading turn PID: predicts each drive beat and checks the DUT output.
module htp_drive_monitor
  import htp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_t               out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 mismatch_count_o,
  output int                 drive_pending_o
);

  localparam longint GAIN_DIV = 22500;

  // Shadow copy of the register file and the controller state
  cfg_t        regs_q;
  logic [15:0] kp_q;
  int          integ_q;
  int          last_err_q;

  out_t drive_fifo[$];
  int   mismatches;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int sgn(input int v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // Run one control tick on the shadow state and return the drive beat it yields
  function automatic out_t next_drive(input in_t tick);
    int     aim, hd, lft, rgt, err, deriv;
    longint m, n, acc, q;
    out_t   res;
    // shortest signed turn error across the wrap
    aim = int'(tick.target_angle) * 128;
    hd  = int'(tick.heading);
    if (aim > hd) begin
      lft = aim - hd;
      rgt = int'(FULL_TURN) - aim + hd;
    end else begin
      lft = int'(FULL_TURN) - hd + aim;
      rgt = hd - aim;
    end
    err = (lft > mag(rgt)) ? -rgt : lft;
    if (err > int'(ERR_MAX)) err = int'(ERR_MAX);
    if (err < -int'(ERR_MAX)) err = -int'(ERR_MAX);
    // proportional gain from the quadratic, only on the first tick of a move
    if (tick.start_move) begin
      m = longint'(mag(err));
      n = m * m - longint'(GAIN_OFS) * m + longint'(GAIN_BIAS);
      kp_q = 16'(n / GAIN_DIV);
    end
    deriv = err - last_err_q;
    // integral: clear past the limit, boost near zero, clear on sign change
    if (mag(integ_q) > int'(regs_q.integral_limit)) begin
      integ_q = 0;
    end else begin
      integ_q += err;
      if (regs_q.integral_gain != '0) begin
        if (mag(err) < int'(regs_q.integral_boost_band)) integ_q += err;
        if (sgn(err) != sgn(last_err_q)) integ_q = 0;
      end
    end
    acc = longint'(err) * longint'(kp_q)
        + longint'(integ_q) * longint'(regs_q.integral_gain)
        + longint'(deriv) * longint'(regs_q.derivative_gain);
    q = (acc + longint'(ROUND_HALF)) >>> 15;
    if (q > longint'(DRIVE_MAX)) q = longint'(DRIVE_MAX);
    if (q < -longint'(DRIVE_MAX)) q = -longint'(DRIVE_MAX);
    res.drive   = q[15:0];
    res.settled = (((q < 0) ? -q : q) < longint'(regs_q.settle_band));
    if (!res.settled) last_err_q = err;
    return res;
  endfunction

  // Output beats are checked before new ticks are predicted, so a stray beat
  // can never be matched against an item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      regs_q.integral_gain       = RST_INTEGRAL_GAIN;
      regs_q.derivative_gain     = RST_DERIVATIVE_GAIN;
      regs_q.integral_limit      = RST_INTEGRAL_LIMIT;
      regs_q.integral_boost_band = RST_BOOST_BAND;
      regs_q.settle_band         = RST_SETTLE_BAND;
      kp_q       = '0;
      integ_q    = 0;
      last_err_q = 0;
      drive_fifo.delete();
      drive_pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (drive_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected drive beat: drive %0d settled %0b",
                     out_data_i.drive, out_data_i.settled);
        end else begin
          want = drive_fifo.pop_front();
          if (want.drive !== out_data_i.drive || want.settled !== out_data_i.settled) begin
            mismatches++;
            if (mismatches <= 10)
              $display("drive mismatch: expected drive %0d settled %0b, got drive %0d settled %0b",
                       want.drive, want.settled, out_data_i.drive, out_data_i.settled);
          end
        end
      end
      // register writes; spare indexes are ignored
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_INTEGRAL_GAIN:   regs_q.integral_gain = cfg_data_i;
          CFG_DERIVATIVE_GAIN: regs_q.derivative_gain = cfg_data_i;
          CFG_INTEGRAL_LIMIT:  regs_q.integral_limit = cfg_data_i;
          CFG_BOOST_BAND:      regs_q.integral_boost_band = cfg_data_i[10:0];
          CFG_SETTLE_BAND:     regs_q.settle_band = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) drive_fifo.push_back(next_drive(in_data_i));
      drive_pending_o <= drive_fifo.size();
    end
    mismatch_count_o <= mismatches;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the heading turn PID testbench: clock, reset, tick and register stimulus, verdict.
module testbench;
  import htp_pkg::*;

  localparam int TICK_LIMIT   = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int SUBDEG       = 128;
  localparam int FULL_SPAN    = int'(FULL_TURN);
  localparam int HALF_SPAN    = FULL_SPAN / 2;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0]        cfg_data_i  = '0;

  int mismatch_count;
  int drive_pending;
  int cycle_count = 0;
  bit stall_request = 1'b0;

  in_t corner_ticks [20];

  heading_turn_pid dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  htp_drive_monitor drive_mon (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .drive_pending_o  (drive_pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TICK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stall pattern that drifts between modes, plus long hold-offs on request
  initial begin
    int       hold_left;
    int       rx_phase;
    rx_mode_e mode;
    hold_left = 0;
    rx_phase  = 0;
    mode      = RX_OPEN;
    forever begin
      @(posedge clk_i);
      rx_phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = rx_mode_e'($urandom_range(0, 3));
        case (mode)
          RX_OPEN:        out_ready_i <= 1'b1;
          RX_COIN:        out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE:      out_ready_i <= ($urandom_range(0, 3) == 0);
          RX_EVERY_THIRD: out_ready_i <= (rx_phase % 3 == 0);
          default:        out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  // Offer one tick and hold it until taken; valid stays high for a following beat
  task automatic send_tick(input in_t tick);
    in_data_i  <= tick;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (drive_pending != 0);
  endtask

  // Let the block go idle, then rewrite every register and poke a spare index
  task automatic reprogram(input logic [15:0] ki, input logic [15:0] kd,
                           input logic [15:0] lim, input logic [15:0] band,
                           input logic [15:0] settle);
    wait_drained();
    write_reg(CFG_INTEGRAL_GAIN, ki);
    write_reg(CFG_DERIVATIVE_GAIN, kd);
    write_reg(CFG_INTEGRAL_LIMIT, lim);
    write_reg(CFG_BOOST_BAND, band);
    write_reg(CFG_SETTLE_BAND, settle);
    write_reg(CfgIdxW'($urandom_range({CfgIdxW{1'b1}}, CFG_SETTLE_BAND + 1)),
              16'($urandom()));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly moves that home in on a target, with overshoots and stray ticks mixed in
  task automatic run_ticks(input int count, input bit steady);
    int  sent, burst_left, gap, move_left, tgt, hd, diff;
    in_t tick;
    move_left  = 0;
    tgt        = 0;
    hd         = 0;
    burst_left = $urandom_range(1, 24);
    for (sent = 0; sent < count; sent++) begin
      if (move_left == 0) begin
        tgt       = $urandom_range(0, 359);
        hd        = $urandom_range(0, FULL_SPAN - 1);
        move_left = $urandom_range(3, 30);
        tick.start_move = 1'b1;
      end else begin
        tick.start_move = ($urandom_range(0, 19) == 0);
      end
      move_left--;
      if ($urandom_range(0, 9) == 0) begin
        // stray tick, fields anywhere in their width
        tick.start_move   = 1'($urandom_range(0, 1));
        tick.target_angle = 9'($urandom_range(0, 511));
        tick.heading      = 16'($urandom_range(0, 65535));
      end else begin
        tick.target_angle = tgt[8:0];
        tick.heading      = hd[15:0];
        diff = tgt * SUBDEG - hd;
        if (diff > HALF_SPAN) diff -= FULL_SPAN;
        else if (diff < -HALF_SPAN) diff += FULL_SPAN;
        if ($urandom_range(0, 3) == 0) hd += diff + diff / 2;
        else hd += diff / 2;
        hd += int'($urandom_range(0, 32)) - 16;
        hd = ((hd % FULL_SPAN) + FULL_SPAN) % FULL_SPAN;
      end
      send_tick(tick);
      if (!steady) begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap        = $urandom_range(0, 8);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end
  endtask

  initial begin
    corner_ticks = '{
      '{1'b0, 9'd90,  16'd0},      // before any move: gain still zero
      '{1'b1, 9'd0,   16'd0},      // on target
      '{1'b1, 9'd359, 16'd0},      // short way back across zero
      '{1'b0, 9'd0,   16'd46079},  // just under a full turn
      '{1'b1, 9'd180, 16'd0},      // exactly half a turn
      '{1'b0, 9'd0,   16'd23040},  // half a turn, other side
      '{1'b1, 9'd511, 16'd0},      // target past 359
      '{1'b1, 9'd0,   16'd65535},  // heading far out, past a full turn
      '{1'b0, 9'd511, 16'd65535},
      '{1'b1, 9'd0,   16'd46080},  // heading at a full turn
      '{1'b1, 9'd100, 16'd12803},  // small negative error, inside boost band
      '{1'b0, 9'd100, 16'd12200},  // sign change
      '{1'b0, 9'd100, 16'd12200},
      '{1'b0, 9'd100, 16'd12200},
      '{1'b0, 9'd100, 16'd12200},  // integral now past its limit
      '{1'b0, 9'd100, 16'd12200},
      '{1'b0, 9'd100, 16'd12805},
      '{1'b0, 9'd100, 16'd12805},
      '{1'b1, 9'd341, 16'd43690},  // alternating bit patterns
      '{1'b0, 9'd170, 16'd21845}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner ticks and a random stretch at reset settings
    foreach (corner_ticks[i]) send_tick(corner_ticks[i]);
    run_ticks(180, 1'b0);

    // both gains and the settle band at their top value, limit and boost band raised
    reprogram(16'hFFFF, 16'hFFFF, 16'd46080, 16'd1024, 16'd32767);
    run_ticks(180, 1'b0);

    // every register at zero
    reprogram('0, '0, '0, '0, '0);
    run_ticks(180, 1'b0);

    // reset values again under back pressure: receiver holds off, sender never idles
    reprogram(RST_INTEGRAL_GAIN, RST_DERIVATIVE_GAIN, RST_INTEGRAL_LIMIT,
              16'(RST_BOOST_BAND), 16'(RST_SETTLE_BAND));
    stall_request = 1'b1;
    run_ticks(180, 1'b1);

    // no integral gain: boost and sign rules skipped
    reprogram('0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 46080)),
              16'($urandom_range(0, 1024)), 16'($urandom_range(0, 512)));
    run_ticks(180, 1'b0);

    // random settings, sometimes with values or bits beyond the usual range
    repeat (4) begin
      reprogram(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 1) ? $urandom_range(0, 46080)
                                         : $urandom_range(0, 65535)),
                16'($urandom_range(0, 1) ? $urandom_range(0, 1024)
                                         : $urandom_range(0, 65535)),
                16'($urandom_range(0, 1) ? $urandom_range(0, 1024)
                                         : $urandom_range(0, 65535)));
      run_ticks(180, 1'b0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && drive_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
